/* hdl/fls_pkg.sv */
// fls_pkg: shared types and constants for the freehand line stepper
// request payload structs, job struct, event codes and stepper states
// no dependencies
`default_nettype none

package fls_pkg;

    localparam int COORD_W             = 6;
    localparam int POINT_W             = 16;
    localparam int DEF_CANVAS_WIDTH    = 64;
    localparam int DEF_CANVAS_HEIGHT   = 64;
    localparam int JOB_DEPTH           = 2;

    // event codes; the fourth code is ignored
    localparam logic [1:0] FUNC_MOVE  = 2'd0;
    localparam logic [1:0] FUNC_PRESS = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic [POINT_W-1:0] point_x;
        logic [POINT_W-1:0] point_y;
        logic               button_held;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic               last;
    } t_out_item;

    // one line segment from start to end point
    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_req;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SETUP,
        BK_RUN
    } t_back_state;

endpackage

`default_nettype wire

/* hdl/fls_front.sv */
// fls_front: accepts pointer events, keeps the previous point and the mode
// register, and turns drawing events into line jobs; uses fls_pkg
`default_nettype none

module fls_front #(
    parameter int CANVAS_WIDTH  = fls_pkg::DEF_CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = fls_pkg::DEF_CANVAS_HEIGHT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire fls_pkg::t_in_item i_item,
    input  wire logic             i_cfg_wr_en,
    input  wire logic             i_cfg_wr_data,
    output fls_pkg::t_job_req     o_job
);

    logic                        r_line_mode;
    logic [fls_pkg::COORD_W-1:0] r_prev_x;
    logic [fls_pkg::COORD_W-1:0] r_prev_y;
    logic                        r_have_prev;

    logic draw;
    logic on_canvas;
    logic forget;
    logic emit_job;

    always_comb begin
        draw   = ((i_item.func == fls_pkg::FUNC_MOVE) && !r_line_mode && i_item.button_held)
              || ((i_item.func == fls_pkg::FUNC_PRESS) && r_line_mode);
        on_canvas = (i_item.point_x < fls_pkg::POINT_W'(CANVAS_WIDTH))
                 && (i_item.point_y < fls_pkg::POINT_W'(CANVAS_HEIGHT));
        // off-canvas points drop the previous point only in follow mode
        forget = ((i_item.func == fls_pkg::FUNC_MOVE) && !r_line_mode && !i_item.button_held)
              || (i_item.func == fls_pkg::FUNC_CLEAR)
              || (draw && !on_canvas && !r_line_mode);
        emit_job = i_accept && draw && on_canvas;

        o_job.valid  = emit_job;
        o_job.job.x1 = i_item.point_x[fls_pkg::COORD_W-1:0];
        o_job.job.y1 = i_item.point_y[fls_pkg::COORD_W-1:0];
        // a lone point starts where it ends
        o_job.job.x0 = r_have_prev ? r_prev_x : i_item.point_x[fls_pkg::COORD_W-1:0];
        o_job.job.y0 = r_have_prev ? r_prev_y : i_item.point_y[fls_pkg::COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have_prev <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_line_mode <= i_cfg_wr_data;
            end
            if (emit_job) begin
                r_prev_x    <= i_item.point_x[fls_pkg::COORD_W-1:0];
                r_prev_y    <= i_item.point_y[fls_pkg::COORD_W-1:0];
                r_have_prev <= 1'b1;
            end else if (i_accept && forget) begin
                r_have_prev <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/fls_job_fifo.sv */
// fls_job_fifo: short queue of line jobs between front and back
// uses fls_pkg for the job type and depth
`default_nettype none

module fls_job_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire fls_pkg::t_job_req i_wr,
    input  wire logic           i_rd,
    output logic                o_full,
    output logic                o_empty,
    output fls_pkg::t_job       o_job
);

    localparam int PTR_W = (fls_pkg::JOB_DEPTH > 1) ? $clog2(fls_pkg::JOB_DEPTH) : 1;
    localparam int CNT_W = $clog2(fls_pkg::JOB_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(fls_pkg::JOB_DEPTH - 1);

    fls_pkg::t_job    r_mem [fls_pkg::JOB_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_wr;
    logic do_rd;

    always_comb begin
        o_full  = (r_count == CNT_W'(fls_pkg::JOB_DEPTH));
        o_empty = (r_count == '0);
        do_wr   = i_wr.valid && !o_full;
        do_rd   = i_rd && !o_empty;
        o_job   = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/fls_back.sv */
// fls_back: steps one line job at a time into an output register, one pixel
// per cycle while pop keeps up; uses fls_pkg for the job, result and state types
`default_nettype none

module fls_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_job_empty,
    input  wire fls_pkg::t_job i_job,
    output logic               o_job_rd,
    output logic               o_empty,
    input  wire logic          i_pop,
    output fls_pkg::t_out_item o_item
);

    localparam int CW = fls_pkg::COORD_W;

    fls_pkg::t_back_state r_state;
    fls_pkg::t_back_state n_state;

    fls_pkg::t_job   r_job;
    logic [CW-1:0]   r_adx;
    logic [CW-1:0]   r_ady;
    logic            r_sx;
    logic            r_sy;
    logic [CW-1:0]   r_steps;
    logic [CW-1:0]   r_i;
    logic [CW-1:0]   r_qx;
    logic [CW-1:0]   r_qy;
    logic [CW-1:0]   r_rx;
    logic [CW-1:0]   r_ry;

    fls_pkg::t_out_item r_out;
    logic               r_out_valid;

    logic          slot_free;
    logic          emit;
    logic          at_end;
    logic [CW:0]   dx;
    logic [CW:0]   dy;
    logic [CW-1:0] adx;
    logic [CW-1:0] ady;
    logic [CW:0]   sum_x;
    logic [CW:0]   sum_y;

    always_comb begin
        slot_free = !r_out_valid || i_pop;
        at_end    = (r_i == r_steps);
        o_job_rd  = 1'b0;
        emit      = 1'b0;
        n_state   = r_state;
        unique case (r_state)
            fls_pkg::BK_IDLE: begin
                if (!i_job_empty) begin
                    o_job_rd = 1'b1;
                    n_state  = fls_pkg::BK_SETUP;
                end
            end
            fls_pkg::BK_SETUP: begin
                n_state = fls_pkg::BK_RUN;
            end
            fls_pkg::BK_RUN: begin
                if (slot_free) begin
                    emit = 1'b1;
                    if (at_end) begin
                        n_state = fls_pkg::BK_IDLE;
                    end
                end
            end
            default: n_state = fls_pkg::BK_IDLE;
        endcase

        dx  = {1'b0, r_job.x1} - {1'b0, r_job.x0};
        dy  = {1'b0, r_job.y1} - {1'b0, r_job.y0};
        adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
        ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];
        // running remainder of i*|d|/steps; |d| <= steps so one subtract is enough
        sum_x = {1'b0, r_rx} + {1'b0, r_adx};
        sum_y = {1'b0, r_ry} + {1'b0, r_ady};

        o_empty = !r_out_valid;
        o_item  = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fls_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_rd) begin
            r_job <= i_job;
        end
        if (r_state == fls_pkg::BK_SETUP) begin
            r_adx   <= adx;
            r_ady   <= ady;
            r_sx    <= dx[CW];
            r_sy    <= dy[CW];
            r_steps <= (adx > ady) ? adx : ady;
            r_i     <= '0;
            r_qx    <= '0;
            r_qy    <= '0;
            r_rx    <= '0;
            r_ry    <= '0;
        end
        if (emit) begin
            r_out.pixel_x <= r_sx ? r_job.x0 - r_qx : r_job.x0 + r_qx;
            r_out.pixel_y <= r_sy ? r_job.y0 - r_qy : r_job.y0 + r_qy;
            r_out.last    <= at_end;
            r_i           <= r_i + 1'b1;
            if (sum_x >= {1'b0, r_steps}) begin
                r_rx <= CW'(sum_x - {1'b0, r_steps});
                r_qx <= r_qx + 1'b1;
            end else begin
                r_rx <= sum_x[CW-1:0];
            end
            if (sum_y >= {1'b0, r_steps}) begin
                r_ry <= CW'(sum_y - {1'b0, r_steps});
                r_qy <= r_qy + 1'b1;
            end else begin
                r_ry <= sum_y[CW-1:0];
            end
        end
    end

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fls_pkg::BK_RUN) |-> (r_i <= r_steps))
        else $error("pixel index ran past the step count");

    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == fls_pkg::BK_RUN) && (r_steps != '0)) |->
            ((r_rx < r_steps) && (r_ry < r_steps)))
        else $error("stepper remainder not below step count");

    a_last_ends_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && at_end) |=> ((r_state == fls_pkg::BK_IDLE) && r_out.last))
        else $error("final pixel did not end the job");

    a_no_pop_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_rd |-> (r_state == fls_pkg::BK_IDLE))
        else $error("job taken while a line is in progress");

endmodule

`default_nettype wire

/* hdl/freehand_line_stepper_unit.sv */
// freehand_line_stepper_unit: top level of the freehand line stepper
// instantiates fls_front, fls_job_fifo and fls_back; uses fls_pkg
//
// Pointer events come in as requests on a queue-style port (push/full) and
// pixels leave on another (empty/pop). An event that draws is turned into a
// line job from the previous point to the new one; a two-entry job queue
// lets the event side keep accepting while the stepper works. A line of n
// pixels (n = steps + 1, at most 64) passes through the stepper in order: it
// takes the job, does setup, then emits one pixel per cycle while pop keeps
// up. The mode register may be written only while the block is idle.
`default_nettype none

module freehand_line_stepper_unit #(
    parameter int CANVAS_WIDTH  = fls_pkg::DEF_CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = fls_pkg::DEF_CANVAS_HEIGHT
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire fls_pkg::t_in_item i_in_item,
    output logic                   empty,
    input  wire logic              pop,
    output fls_pkg::t_out_item     o_out_item,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_wr_data
);

    fls_pkg::t_job_req job_req;
    fls_pkg::t_job     fifo_job;
    logic              fifo_full;
    logic              fifo_empty;
    logic              fifo_rd;
    logic              accept;

    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    fls_front #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (i_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_job         (job_req)
    );

    fls_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_req),
        .i_rd    (fifo_rd),
        .o_full  (fifo_full),
        .o_empty (fifo_empty),
        .o_job   (fifo_job)
    );

    fls_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (fifo_empty),
        .i_job       (fifo_job),
        .o_job_rd    (fifo_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_out_item)
    );

endmodule

`default_nettype wire
